/* design/lfrm_pkg.sv */
// Shared constants, types and FSM states of the line framer.
package lfrm_pkg;

    // Longest line that is delivered, not counting one trailing carriage return
    localparam int LINE_LIMIT  = 64;
    localparam int STORE_DEPTH = LINE_LIMIT + 1;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int BYTE_W      = 8;

    localparam logic [BYTE_W-1:0] BYTE_NL = 8'd10;
    localparam logic [BYTE_W-1:0] BYTE_CR = 8'd13;

    // Result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_ERR  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } t_state;

    // Load command from the controller to the output register
    typedef struct packed {
        logic load;
        logic is_err;
        logic last;
    } t_oreg_cmd;

endpackage

/* design/lfrm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module lfrm_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 65,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/lfrm_oreg.sv */
// Output register of the result channel.
module lfrm_oreg import lfrm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_oreg_cmd         i_cmd,
    input  logic [BYTE_W-1:0] i_rd_data,
    output logic              o_free,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_kind,
    output logic [BYTE_W-1:0] o_line_byte,
    output logic              o_last_of_line
);

    logic              r_valid;
    logic              r_kind;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;

    // Slot can take a new item when empty or being drained now
    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload: error results carry a zero byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_cmd.is_err ? KIND_ERR : KIND_DATA;
            r_byte <= i_cmd.is_err ? '0 : i_rd_data;
            r_last <= i_cmd.last;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_kind         = r_kind;
    assign o_line_byte    = r_byte;
    assign o_last_of_line = r_last;

endmodule

/* design/lfrm_ctrl.sv */
// Line controller: fill count, drop mode, store access and line readout.
module lfrm_ctrl import lfrm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_byte_in,
    input  logic              i_oreg_free,
    output logic              o_wr_en,
    output logic [ADDR_W-1:0] o_wr_addr,
    output logic [BYTE_W-1:0] o_wr_data,
    output logic              o_rd_en,
    output logic [ADDR_W-1:0] o_rd_addr,
    output t_oreg_cmd         o_cmd
);

    localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LINE_LIMIT);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_fill,  n_fill;
    logic              r_drop,  n_drop;
    logic              r_last_cr, n_last_cr;
    logic [ADDR_W-1:0] r_idx,   n_idx;
    logic [CNT_W-1:0]  r_len,   n_len;

    logic             accept;
    logic             is_nl;
    logic             is_cr;
    logic             fits;
    logic [CNT_W-1:0] nl_len;
    logic             idx_last;

    assign accept = i_in_valid && o_in_ready;
    assign is_nl  = (i_byte_in == BYTE_NL);
    assign is_cr  = (i_byte_in == BYTE_CR);
    assign fits   = (r_fill < LIMIT_C) || ((r_fill == LIMIT_C) && is_cr);
    // Line length with one trailing carriage return removed
    assign nl_len = r_fill - CNT_W'(r_last_cr && (r_fill != '0));
    assign idx_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_len);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && is_nl && !r_drop && (nl_len != '0)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_oreg_free) begin
                    n_state = idx_last ? ST_IDLE : ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_fill[ADDR_W-1:0];
        o_wr_data  = i_byte_in;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_idx;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_oreg_free;
                if (accept && !is_nl && !r_drop) begin
                    if (fits) begin
                        o_wr_en = 1'b1;
                    end else begin
                        o_cmd.load   = 1'b1;
                        o_cmd.is_err = 1'b1;
                        o_cmd.last   = 1'b1;
                    end
                end
            end
            ST_READ: begin
                o_rd_en = 1'b1;
            end
            ST_LOAD: begin
                if (i_oreg_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.last = idx_last;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Line bookkeeping
    always_comb begin
        n_fill    = r_fill;
        n_drop    = r_drop;
        n_last_cr = r_last_cr;
        n_idx     = r_idx;
        n_len     = r_len;
        if (accept) begin
            if (is_nl) begin
                n_fill    = '0;
                n_drop    = 1'b0;
                n_last_cr = 1'b0;
                n_idx     = '0;
                n_len     = nl_len;
            end else if (!r_drop) begin
                if (fits) begin
                    n_fill    = r_fill + CNT_W'(1);
                    n_last_cr = is_cr;
                end else begin
                    n_fill    = '0;
                    n_drop    = 1'b1;
                    n_last_cr = 1'b0;
                end
            end
        end
        if ((r_state == ST_LOAD) && i_oreg_free) begin
            n_idx = r_idx + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_drop    <= 1'b0;
            r_last_cr <= 1'b0;
            r_idx     <= '0;
            r_len     <= '0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_drop    <= n_drop;
            r_last_cr <= n_last_cr;
            r_idx     <= n_idx;
            r_len     <= n_len;
        end
    end

endmodule

/* design/line_framer_with_overflow_drop_core.sv */
// Top level of the newline-delimited line framer with overflow drop.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------------------------------
//   input    | i_in_valid / o_in_ready  | i_byte_in
//   output   | o_out_valid / i_out_ready| o_kind, o_line_byte, o_last_of_line
//
// An ordinary byte is written to the line store at the fill count. On a
// newline each delivered byte is first read from the store and then loaded
// into the output register, the load waiting while that register is not
// free; input is held off during that readout. Synchronous active-low
// reset clears the control state; store contents are undefined until
// written. A stalled output holds off the input only while the output
// register is full and not being taken.
module line_framer_with_overflow_drop_core import lfrm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_byte_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_kind,
    output logic [BYTE_W-1:0] o_line_byte,
    output logic              o_last_of_line
);

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              oreg_free;
    t_oreg_cmd         cmd;

    lfrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_byte_in   (i_byte_in),
        .i_oreg_free (oreg_free),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_cmd       (cmd)
    );

    lfrm_ram #(
        .DATA_W (BYTE_W),
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lfrm_oreg u_oreg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_rd_data      (rd_data),
        .o_free         (oreg_free),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_line_byte    (o_line_byte),
        .o_last_of_line (o_last_of_line)
    );

endmodule

/* design/lfrm_chk.sv */
// Port-level checker of the line framer, bound to the top level.
module lfrm_chk import lfrm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic [BYTE_W-1:0] i_byte_in,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_kind,
    input logic [BYTE_W-1:0] o_line_byte,
    input logic              o_last_of_line
);

    // Output item holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_kind) && $stable(o_line_byte) && $stable(o_last_of_line))
        else $error("output payload changed while stalled");

    // Error results carry a zero byte and close the line
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_ERR) |-> (o_line_byte == '0) && o_last_of_line)
        else $error("malformed error item");

    // Input is only taken when the output slot can absorb a result
    a_ready_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && o_out_valid |-> i_out_ready)
        else $error("input ready while output slot blocked");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind line_framer_with_overflow_drop_core lfrm_chk u_lfrm_chk (.*);
